// ===== rtl/tiled_texture_swizzle_writer_macros.svh =====
// Assertion helpers shared by the swizzle writer.
`ifndef TILED_TEXTURE_SWIZZLE_WRITER_MACROS_SVH
`define TILED_TEXTURE_SWIZZLE_WRITER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TTSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TTSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttsw_pkg.sv =====
`default_nettype none

package ttsw_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int DIM_W      = 11;
  localparam int CNT_W      = 10;
  localparam int ADDR_W     = 22;
  localparam int DATA_W     = 16;
  localparam int COMP_W     = 8;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    MODE_RGBA8 = 2'd0,
    MODE_RGB24 = 2'd1,
    MODE_IA4   = 2'd2,
    MODE_I4    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SIZE_NIB_HI = 2'd0,
    SIZE_NIB_LO = 2'd1,
    SIZE_BYTE   = 2'd2,
    SIZE_HALF   = 2'd3
  } size_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  // Clamp a dimension register into 1..MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tiled_texture_swizzle_writer.sv =====
// Channel | Direction | Handshake        | Beat carries
// in_     | input     | in_valid/ready   | one source pixel, bytes a..d
// out_    | output    | out_valid/ready  | one tiled-buffer write
// cfg_    | input     | cfg_write_en     | one register write, no wait
//
// A pixel is taken into the input register, and its writes leave from the result
// register. RGBA8 and RGB24 pixels give two writes through the single result register,
// so the input register holds each such pixel until its second write is loaded; IA4
// and I4 sustain one pixel per cycle while the output does not stall.
// Reset is synchronous and active low; it clears the counters and the valid flags.
// Either side may stall at any time; a held result stalls the input only once the
// input register also holds a pixel.
`default_nettype none

module tiled_texture_swizzle_writer
  import ttsw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COMP_W-1:0]     in_comp_a,
  input  wire logic [COMP_W-1:0]     in_comp_b,
  input  wire logic [COMP_W-1:0]     in_comp_c,
  input  wire logic [COMP_W-1:0]     in_comp_d,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ADDR_W-1:0]          out_write_address,
  output logic [DATA_W-1:0]          out_write_data,
  output logic [1:0]                 out_write_size,
  output logic                       out_last_of_pixel,
  output logic                       out_end_of_image
);

  // Configuration and position state
  mode_t             mode_cfg_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] band_r, band_nxt;

  // Input register
  logic              s1_valid_r;
  logic              phase_r;
  mode_t             s1_mode_r;
  logic [COMP_W-1:0] s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [CNT_W-1:0]  s1_x_r;
  logic [2:0]        s1_y_r;
  logic [ADDR_W-1:0] s1_band_r;
  logic              s1_eoi_r;

  // Result register
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic [1:0]        out_size_r;
  logic              out_last_r;
  logic              out_eoi_r;

  logic              in_fire;
  logic              out_load;
  logic              s1_done;
  logic              cfg_hit;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              last_col, last_row, eoi_now;
  logic [DIM_W-1:0]  row_inc;
  logic [ADDR_W-1:0] pitch;
  logic              band_step;

  logic [ADDR_W-1:0] res_addr;
  logic [DATA_W-1:0] res_data;
  size_t             res_size;
  logic              res_last;

  assign cfg_hit = cfg_write_en && ((cfg_index == CFG_PIXEL_MODE) ||
                   (cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_done  = out_load &&
                    (phase_r || (s1_mode_r == MODE_IA4) || (s1_mode_r == MODE_I4));
  assign in_ready = !s1_valid_r || s1_done;
  assign in_fire  = in_valid && in_ready;

  // Position bookkeeping for the pixel being accepted.
  always_comb begin
    w_eff     = eff_dim(width_r);
    h_eff     = eff_dim(height_r);
    last_col  = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
    last_row  = ({1'b0, row_r} + DIM_W'(1)) >= h_eff;
    eoi_now   = last_col && last_row;
    row_inc   = {1'b0, row_r} + DIM_W'(1);
    if ((mode_cfg_r == MODE_RGBA8) || (mode_cfg_r == MODE_RGB24)) begin
      pitch = ADDR_W'({(w_eff + DIM_W'(3)) & ~DIM_W'(3), 4'b0000});
    end else begin
      pitch = ADDR_W'({(w_eff + DIM_W'(7)) & ~DIM_W'(7), 2'b00});
    end
    // A new band starts when the next row crosses a tile boundary.
    if (mode_cfg_r == MODE_I4) begin
      band_step = (row_inc[2:0] == 3'd0);
    end else begin
      band_step = (row_inc[1:0] == 2'd0);
    end

    col_nxt  = col_r;
    row_nxt  = row_r;
    band_nxt = band_r;
    if (!last_col) begin
      col_nxt = col_r + CNT_W'(1);
    end else begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt  = '0;
        band_nxt = '0;
      end else begin
        row_nxt = row_inc[CNT_W-1:0];
        if (band_step) begin
          band_nxt = band_r + pitch;
        end
      end
    end
  end

  // Result formatting from the input register.
  always_comb begin
    res_addr = s1_band_r;
    res_data = '0;
    res_size = SIZE_HALF;
    res_last = 1'b1;
    unique case (s1_mode_r)
      MODE_RGBA8, MODE_RGB24: begin
        // Second byte pair of each texel sits 32 bytes into the tile.
        res_addr = s1_band_r + ADDR_W'({s1_x_r[9:2], phase_r, s1_y_r[1:0],
                                        s1_x_r[1:0], 1'b0});
        res_size = SIZE_HALF;
        res_last = phase_r;
        if (s1_mode_r == MODE_RGBA8) begin
          res_data = phase_r ? {s1_c_r, s1_d_r} : {s1_a_r, s1_b_r};
        end else begin
          res_data = phase_r ? {s1_b_r, s1_c_r} : {8'hff, s1_a_r};
        end
      end
      MODE_IA4: begin
        res_addr = s1_band_r + ADDR_W'({s1_x_r[9:3], s1_y_r[1:0], s1_x_r[2:0]});
        res_data = {8'h00, s1_b_r[7:4], s1_a_r[7:4]};
        res_size = SIZE_BYTE;
      end
      MODE_I4: begin
        res_addr = s1_band_r + ADDR_W'({s1_x_r[9:3], s1_y_r[2:0], s1_x_r[2:1]});
        res_data = {12'h000, s1_a_r[7:4]};
        res_size = s1_x_r[0] ? SIZE_NIB_LO : SIZE_NIB_HI;
      end
      default: begin
        res_addr = s1_band_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r  <= MODE_RGBA8;
      width_r     <= DIM_W'(1);
      height_r    <= DIM_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      band_r      <= '0;
      s1_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        unique case (cfg_index)
          CFG_PIXEL_MODE:   mode_cfg_r <= mode_t'(cfg_data[1:0]);
          CFG_IMAGE_WIDTH:  width_r    <= cfg_data;
          CFG_IMAGE_HEIGHT: height_r   <= cfg_data;
          default:          mode_cfg_r <= mode_cfg_r;
        endcase
        col_r  <= '0;
        row_r  <= '0;
        band_r <= '0;
      end else if (in_fire) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        band_r <= band_nxt;
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
        phase_r    <= 1'b0;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
        phase_r    <= 1'b0;
      end else if (out_load) begin
        phase_r <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= mode_cfg_r;
      s1_a_r    <= in_comp_a;
      s1_b_r    <= in_comp_b;
      s1_c_r    <= in_comp_c;
      s1_d_r    <= in_comp_d;
      s1_x_r    <= col_r;
      s1_y_r    <= row_r[2:0];
      s1_band_r <= band_r;
      s1_eoi_r  <= eoi_now;
    end
    if (out_load) begin
      out_addr_r <= res_addr;
      out_data_r <= res_data;
      out_size_r <= res_size;
      out_last_r <= res_last;
      out_eoi_r  <= res_last && s1_eoi_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_write_size    = out_size_r;
  assign out_last_of_pixel = out_last_r;
  assign out_end_of_image  = out_eoi_r;

`include "tiled_texture_swizzle_writer_macros.svh"

  `TTSW_ASSERT_NOW(a_second_half_rgba, s1_valid_r && phase_r, (s1_mode_r == MODE_RGBA8) || (s1_mode_r == MODE_RGB24), "second write phase outside a two-write mode")
  `TTSW_ASSERT_NOW(a_eoi_is_last, out_valid && out_end_of_image, out_last_of_pixel, "end of image on a write that is not the last of its pixel")
  `TTSW_ASSERT_NEXT(a_eoi_wraps, in_fire && eoi_now && !cfg_hit, (col_r == '0) && (row_r == '0) && (band_r == '0), "counters did not return to zero after the last pixel")
  `TTSW_ASSERT_NEXT(a_cfg_restart, cfg_hit, (col_r == '0) && (row_r == '0) && (band_r == '0), "register write did not restart the image")

endmodule

`default_nettype wire

// ===== tb/tb_tiled_texture_swizzle_writer.sv =====
`default_nettype none

module tb_tiled_texture_swizzle_writer;
  import ttsw_pkg::*;

  typedef struct {
    logic [COMP_W-1:0] a;
    logic [COMP_W-1:0] b;
    logic [COMP_W-1:0] c;
    logic [COMP_W-1:0] d;
  } pixel_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    size_t             size;
    logic              last;
    logic              eoi;
  } tile_write_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COMP_W-1:0]    in_comp_a = '0;
  logic [COMP_W-1:0]    in_comp_b = '0;
  logic [COMP_W-1:0]    in_comp_c = '0;
  logic [COMP_W-1:0]    in_comp_d = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    out_write_address;
  logic [DATA_W-1:0]    out_write_data;
  logic [1:0]           out_write_size;
  logic                 out_last_of_pixel;
  logic                 out_end_of_image;

  tiled_texture_swizzle_writer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_comp_a         (in_comp_a),
    .in_comp_b         (in_comp_b),
    .in_comp_c         (in_comp_c),
    .in_comp_d         (in_comp_d),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_size    (out_write_size),
    .out_last_of_pixel (out_last_of_pixel),
    .out_end_of_image  (out_end_of_image)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and raster position.
  mode_t             cur_mode = MODE_RGBA8;
  logic [DIM_W-1:0]  reg_w = DIM_W'(1);
  logic [DIM_W-1:0]  reg_h = DIM_W'(1);
  logic [CNT_W-1:0]  col = '0;
  logic [CNT_W-1:0]  row = '0;
  logic [ADDR_W-1:0] band = '0;

  pixel_t      pixels_to_send[$];
  tile_write_t tile_writes_due[$];
  tile_write_t oldest_write;
  pixel_t      next_pixel;
  int          sent_total = 0;
  int          mismatches = 0;
  int          src_gap_pct = 0;
  int          sink_stall_pct = 0;

  function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  // Works out the buffer writes of one pixel and advances the raster position.
  task automatic swizzle_pixel(input pixel_t px);
    logic [31:0] we, he, x, y, base, pitch, tile_h;
    logic        lc, lr;
    tile_write_t first, final_wr;
    we = effective_dim(reg_w);
    he = effective_dim(reg_h);
    x = col;
    y = row;
    lc = (x + 1 >= we);
    lr = (y + 1 >= he);
    first.last = 1'b0;
    first.eoi = 1'b0;
    final_wr.last = 1'b1;
    final_wr.eoi = lc && lr;
    case (cur_mode)
      MODE_RGBA8, MODE_RGB24: begin
        tile_h = 4;
        pitch = ((we + 3) & ~32'd3) * 16;
        base = band + (x >> 2) * 64 + ((y & 3) * 4 + (x & 3)) * 2;
        first.addr = ADDR_W'(base);
        final_wr.addr = ADDR_W'(base + 32);
        first.size = SIZE_HALF;
        final_wr.size = SIZE_HALF;
        if (cur_mode == MODE_RGBA8) begin
          first.data = {px.a, px.b};
          final_wr.data = {px.c, px.d};
        end else begin
          first.data = {8'hff, px.a};
          final_wr.data = {px.b, px.c};
        end
        tile_writes_due.push_back(first);
      end
      MODE_IA4: begin
        tile_h = 4;
        pitch = ((we + 7) & ~32'd7) * 4;
        final_wr.addr = ADDR_W'(band + (x >> 3) * 32 + (y & 3) * 8 + (x & 7));
        final_wr.data = {8'h00, (px.b & 8'hf0) | (px.a >> 4)};
        final_wr.size = SIZE_BYTE;
      end
      MODE_I4: begin
        tile_h = 8;
        pitch = ((we + 7) & ~32'd7) * 4;
        final_wr.addr = ADDR_W'(band + (x >> 3) * 32 + (y & 7) * 4 + ((x & 7) >> 1));
        final_wr.data = {12'h000, px.a[7:4]};
        final_wr.size = x[0] ? SIZE_NIB_LO : SIZE_NIB_HI;
      end
    endcase
    tile_writes_due.push_back(final_wr);

    if (!lc) begin
      col = CNT_W'(x + 1);
    end else begin
      col = '0;
      if (lr) begin
        row = '0;
        band = '0;
      end else begin
        row = CNT_W'(y + 1);
        if (((y + 1) & (tile_h - 1)) == 0) band = ADDR_W'(band + pitch);
      end
    end
  endtask

  // Driver: a beat is predicted when it is taken, then the next pixel may be offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_pixel.a = in_comp_a;
        next_pixel.b = in_comp_b;
        next_pixel.c = in_comp_c;
        next_pixel.d = in_comp_d;
        swizzle_pixel(next_pixel);
      end
      if (!in_valid || in_ready) begin
        if (pixels_to_send.size() > 0 && $urandom_range(99) >= src_gap_pct) begin
          next_pixel = pixels_to_send.pop_front();
          in_valid <= 1'b1;
          in_comp_a <= next_pixel.a;
          in_comp_b <= next_pixel.b;
          in_comp_c <= next_pixel.c;
          in_comp_d <= next_pixel.d;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: every accepted write beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tile_writes_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected write: addr %h data %h size %0d last %b eoi %b",
                   out_write_address, out_write_data, out_write_size,
                   out_last_of_pixel, out_end_of_image);
        mismatches++;
      end else begin
        oldest_write = tile_writes_due.pop_front();
        if (out_write_address !== oldest_write.addr || out_write_data !== oldest_write.data ||
            out_write_size !== oldest_write.size || out_last_of_pixel !== oldest_write.last ||
            out_end_of_image !== oldest_write.eoi) begin
          if (mismatches < 10)
            $display("write mismatch: expected addr %h data %h size %0d last %b eoi %b, got addr %h data %h size %0d last %b eoi %b",
                     oldest_write.addr, oldest_write.data, oldest_write.size,
                     oldest_write.last, oldest_write.eoi,
                     out_write_address, out_write_data, out_write_size,
                     out_last_of_pixel, out_end_of_image);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_PIXEL_MODE:   cur_mode = mode_t'(val[1:0]);
      CFG_IMAGE_WIDTH:  reg_w = val;
      CFG_IMAGE_HEIGHT: reg_h = val;
      default: ;
    endcase
    // Any register write restarts the image.
    col = '0;
    row = '0;
    band = '0;
  endtask

  task automatic configure(input logic [2:0] which, input logic [DIM_W-1:0] m,
                           input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    if (which[0]) write_reg(CFG_PIXEL_MODE, m);
    if (which[1]) write_reg(CFG_IMAGE_WIDTH, w);
    if (which[2]) write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic queue_pixel(input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input logic [7:0] d);
    pixel_t px;
    px.a = a;
    px.b = b;
    px.c = c;
    px.d = d;
    pixels_to_send.push_back(px);
    sent_total++;
  endtask

  // The sender holds off until every predicted write has come back. The check runs
  // on the falling edge so that the driver's updates of the rising edge are settled.
  task automatic wait_idle();
    while (pixels_to_send.size() > 0 || in_valid || tile_writes_due.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pacing();
    if (sent_total < 567) begin
      src_gap_pct = 27;
      sink_stall_pct = 57;
    end else if (sent_total < 1134) begin
      src_gap_pct = 57;
      sink_stall_pct = 27;
    end else begin
      src_gap_pct = 0;
      sink_stall_pct = 0;
    end
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 55) return DIM_W'($urandom_range(1, 12));
    if (r < 65) return '0;
    if (r < 72) return DIM_W'(MAX_DIM);
    if (r < 80) return DIM_W'($urandom_range(MAX_DIM + 1, 2047));
    return DIM_W'($urandom_range(13, 300));
  endfunction

  initial begin
    logic [2:0]       which;
    logic [DIM_W-1:0] m, w, h;
    int               img, count;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_pacing();

    // Reset settings: one-pixel RGBA8 image, so every pixel ends the image.
    queue_pixel(8'hff, 8'h00, 8'hff, 8'h00);
    queue_pixel(8'h00, 8'hff, 8'h00, 8'hff);
    wait_idle();

    // Zero height counts as one row; three pixels wrap past the image end.
    configure(3'b111, MODE_RGB24, DIM_W'(2), DIM_W'(0));
    queue_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(8'h0f, 8'hf0, 8'h0f, 8'hf0);
    wait_idle();

    configure(3'b111, MODE_IA4, DIM_W'(0), DIM_W'(3));
    queue_pixel(8'hff, 8'h00, 8'h5a, 8'ha5);
    queue_pixel(8'h00, 8'hff, 8'ha5, 8'h5a);
    queue_pixel(8'hf0, 8'h0f, 8'hff, 8'h00);
    queue_pixel(8'h0f, 8'hf0, 8'h00, 8'hff);
    wait_idle();

    // Height above the maximum is clamped.
    configure(3'b111, MODE_I4, DIM_W'(3), DIM_W'(2047));
    queue_pixel(8'hff, 8'h12, 8'h34, 8'h56);
    queue_pixel(8'h00, 8'hed, 8'hcb, 8'ha9);
    queue_pixel(8'hf0, 8'h00, 8'h00, 8'h00);
    queue_pixel(8'h0f, 8'hff, 8'hff, 8'hff);
    queue_pixel(8'h80, 8'h01, 8'h02, 8'h03);
    queue_pixel(8'h7f, 8'hfe, 8'hfd, 8'hfc);
    wait_idle();

    configure(3'b011, MODE_RGBA8, DIM_W'(2047), DIM_W'(0));
    queue_pixel(8'h01, 8'h80, 8'h7f, 8'hfe);
    queue_pixel(8'hfe, 8'h7f, 8'h80, 8'h01);
    queue_pixel(8'haa, 8'h55, 8'haa, 8'h55);
    queue_pixel(8'h55, 8'haa, 8'h55, 8'haa);
    wait_idle();

    while (sent_total < 1700) begin
      which = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'b111;
      // Upper bits of a mode write are junk that the block must ignore.
      m = {9'($urandom), 2'($urandom_range(3))};
      w = pick_dim();
      h = pick_dim();
      configure(which, m, w, h);
      set_pacing();
      img = effective_dim(reg_w) * effective_dim(reg_h);
      if (img <= 48) count = img * $urandom_range(1, 3) + $urandom_range(0, 2);
      else count = $urandom_range(16, 120);
      repeat (count)
        queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && tile_writes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
